[sv/crr_pkg.sv]
// Shared constants, types and codes for the copy-on-write block request router.
`timescale 1ns / 1ps

package crr_pkg;

	// Geometry of the store
	localparam int BLOCK_BYTES = 4096;
	localparam int MAP_BLOCKS  = 65536;
	localparam int MAX_CHUNKS  = 64;

	// Fixed field widths
	localparam int OFF_W     = 28;
	localparam int CNT_W     = 18;
	localparam int SIZE_W    = 29;
	localparam int BLKN_W    = 16;
	localparam int BOFFO_W   = 12;
	localparam int CHUNK_W   = 13;
	localparam int SVB_W     = 13;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;

	// Derived widths
	localparam int BOFF_W = $clog2(BLOCK_BYTES);
	localparam int LEN_W  = BOFF_W + 1;
	localparam int CUR_W  = OFF_W + 1;
	localparam int CMP_W  = (CUR_W > SIZE_W) ? CUR_W : SIZE_W;
	localparam int SPAN_W = CNT_W + 2;
	localparam int MAP_W  = $clog2(MAP_BLOCKS);

	// Present bitmap is kept as rows of bits in a RAM
	localparam int ROW_BITS  = 32;
	localparam int ROW_SEL_W = $clog2(ROW_BITS);
	localparam int ROWS      = MAP_BLOCKS / ROW_BITS;
	localparam int ROW_W     = $clog2(ROWS);

	// Request queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Stream payload widths
	localparam int IN_TDATA_W  = ((OFF_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = BLKN_W + BOFFO_W + CHUNK_W + SVB_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = ACT_W + STAT_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_OV_READ    = 3'd0,
		ACT_ORIG_READ  = 3'd1,
		ACT_FULL_WRITE = 3'd2,
		ACT_SEED_OV    = 3'd3,
		ACT_SEED_ORIG  = 3'd4,
		ACT_NONE       = 3'd5
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_WPROT = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIG_SIZE  = 2'd0,
		CFG_HAS_ORIG   = 2'd1,
		CFG_OV_PRESENT = 2'd2,
		CFG_WPROT      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ISSUE,
		BK_DECIDE
	} bk_state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] orig_size;
		logic              has_orig;
		logic              ov_present;
		logic              wprot;
	} cfg_t;

	// One classified request waiting for the back end
	typedef struct packed {
		logic             func;
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] cnt;
		logic             special;
		stat_t            status;
	} req_t;

	// One command leaving the block
	typedef struct packed {
		logic [BLKN_W-1:0]  blk;
		logic [BOFFO_W-1:0] boff;
		logic [CHUNK_W-1:0] chunk;
		act_t               act;
		logic [SVB_W-1:0]   svb;
		stat_t              status;
		logic               last;
	} res_t;

endpackage

[sv/cow_block_request_router.sv]
// Top level of the copy-on-write block request router.
`timescale 1ns / 1ps

// Splits each read or write request into block-aligned chunks and issues one
// routing command per chunk (overlay read, original read, full-block write or
// seeded read-modify-write), marking written blocks in an on-chip present
// bitmap. After reset the bitmap is cleared one 32-block row per cycle, during
// which s_tready stays low; config writes are accepted at any time but must only
// be made while idle. A request that is split leaves the queue, then each chunk
// takes a bitmap row read and then a decide and write-back step, as set by the
// registered read of the bitmap RAM; an empty or refused request is turned into
// its one result straight from the idle state. A two-entry queue lets new
// requests be accepted while the back end works, and the result register lets
// the next one be prepared while a finished command waits on m_tready.

module cow_block_request_router (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crr_pkg::SIZE_W-1:0]          cfg_data,
	// Request stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [crr_pkg::IN_TDATA_W-1:0]      s_tdata,   // byte_offset, byte_count
	input  logic                                s_tuser,   // func
	// Command stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [crr_pkg::OUT_TDATA_W-1:0]     m_tdata,   // block_number, offset_in_block,
	                                                       // chunk_bytes, source_valid_bytes
	output logic [crr_pkg::OUT_TUSER_W-1:0]     m_tuser,   // action, status
	output logic                                m_tlast    // last
);

	crr_pkg::cfg_t cfg;
	crr_pkg::req_t push_data;
	crr_pkg::req_t head;
	crr_pkg::res_t res;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	logic          clr_done;

	assign cfg_ready = 1'b1;

	crr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.clr_done  (clr_done),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data),
		.cfg       (cfg)
	);

	crr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	crr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.empty    (q_empty),
		.head     (head),
		.pop      (pop),
		.clr_done (clr_done),
		.m_valid  (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// Pack the command, first field in the lowest bits
	assign m_tdata = crr_pkg::OUT_TDATA_W'({res.svb, res.chunk, res.boff, res.blk});
	assign m_tuser = {res.status, res.act};
	assign m_tlast = res.last;

endmodule

[sv/crr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module crr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[sv/crr_front.sv]
// Front end: configuration registers, request intake and classification.
`timescale 1ns / 1ps

module crr_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [crr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crr_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [crr_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                               s_tuser,
	input  logic                               clr_done,
	input  logic                               q_full,
	output logic                               push,
	output crr_pkg::req_t                      push_data,
	output crr_pkg::cfg_t                      cfg
);

	crr_pkg::cfg_t               cfg_q;
	logic [crr_pkg::OFF_W-1:0]   off;
	logic [crr_pkg::CNT_W-1:0]   cnt;
	logic [crr_pkg::SPAN_W-1:0]  span;
	logic [crr_pkg::CUR_W-1:0]   last_byte;
	logic                        wr_rej;
	logic                        too_many;
	logic                        beyond;

	// Configuration writes, taken at any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orig_size  <= '0;
			cfg_q.has_orig   <= 1'b0;
			cfg_q.ov_present <= 1'b0;
			cfg_q.wprot      <= 1'b1;
		end else if (cfg_valid) begin
			unique case (crr_pkg::cfg_idx_t'(cfg_index))
				crr_pkg::CFG_ORIG_SIZE:  cfg_q.orig_size  <= cfg_data;
				crr_pkg::CFG_HAS_ORIG:   cfg_q.has_orig   <= cfg_data[0];
				crr_pkg::CFG_OV_PRESENT: cfg_q.ov_present <= cfg_data[0];
				crr_pkg::CFG_WPROT:      cfg_q.wprot      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// Unpack the item
	assign off = s_tdata[crr_pkg::OFF_W-1:0];
	assign cnt = s_tdata[crr_pkg::OFF_W+crr_pkg::CNT_W-1:crr_pkg::OFF_W];

	// Intake stops during the bitmap clear and when the queue is full
	assign s_tready = clr_done && !q_full;
	assign push     = s_tvalid && s_tready;

	// Range checks: chunk count and block of the last byte
	assign span = crr_pkg::SPAN_W'(off[crr_pkg::BOFF_W-1:0]) + crr_pkg::SPAN_W'(cnt)
		+ crr_pkg::SPAN_W'(crr_pkg::BLOCK_BYTES - 1);
	assign too_many  = (span >> crr_pkg::BOFF_W) > crr_pkg::SPAN_W'(crr_pkg::MAX_CHUNKS);
	assign last_byte = crr_pkg::CUR_W'(off) + crr_pkg::CUR_W'(cnt) - crr_pkg::CUR_W'(1);
	assign beyond    = (last_byte >> crr_pkg::BOFF_W) >= crr_pkg::CUR_W'(crr_pkg::MAP_BLOCKS);
	assign wr_rej    = s_tuser && (cfg_q.wprot || !cfg_q.ov_present);

	// Classify: rejected write first, then empty, then out of range
	always_comb begin
		push_data.func    = s_tuser;
		push_data.off     = off;
		push_data.cnt     = cnt;
		push_data.special = 1'b0;
		push_data.status  = crr_pkg::STAT_OK;
		if (wr_rej) begin
			push_data.special = 1'b1;
			push_data.status  = crr_pkg::STAT_WPROT;
		end else if (cnt == '0) begin
			push_data.special = 1'b1;
		end else if (too_many || beyond) begin
			push_data.special = 1'b1;
			push_data.status  = crr_pkg::STAT_RANGE;
		end
	end

endmodule

[sv/crr_queue.sv]
// Short request queue between the front and the back end.
`timescale 1ns / 1ps

module crr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  crr_pkg::req_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output crr_pkg::req_t head
);

	crr_pkg::req_t                 slot_q [crr_pkg::Q_DEPTH];
	logic [crr_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [crr_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [crr_pkg::Q_CNT_W-1:0]   count_q;

	assign full  = count_q == crr_pkg::Q_CNT_W'(crr_pkg::Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == crr_pkg::Q_PTR_W'(crr_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + crr_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == crr_pkg::Q_PTR_W'(crr_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + crr_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + crr_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - crr_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

[sv/crr_back.sv]
// Back end: bitmap clear, chunk splitting, routing decision and result register.
`timescale 1ns / 1ps

module crr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  crr_pkg::cfg_t cfg,
	input  logic          empty,
	input  crr_pkg::req_t head,
	output logic          pop,
	output logic          clr_done,
	output logic          m_valid,
	input  logic          m_tready,
	output crr_pkg::res_t res
);

	crr_pkg::bk_state_t            state_q, state_d;
	logic [crr_pkg::CUR_W-1:0]     cur_q;
	logic [crr_pkg::CNT_W-1:0]     left_q;
	logic                          func_q;
	logic [crr_pkg::ROW_W-1:0]     clr_q;

	logic [crr_pkg::MAP_W-1:0]     map_idx_s1;
	logic [crr_pkg::BLKN_W-1:0]    blkn_s1;
	logic [crr_pkg::BOFF_W-1:0]    boff_s1;
	logic [crr_pkg::LEN_W-1:0]     len_s1;
	logic [crr_pkg::CMP_W-1:0]     avail_s1;

	logic                          out_valid_q;
	crr_pkg::res_t                 out_q;

	logic [crr_pkg::CUR_W-1:0]     cur_blk;
	logic [crr_pkg::LEN_W-1:0]     room;
	logic [crr_pkg::LEN_W-1:0]     len_c;
	logic [crr_pkg::CUR_W-1:0]     pos;
	logic [crr_pkg::CMP_W-1:0]     pos_cmp;
	logic [crr_pkg::CMP_W-1:0]     size_cmp;
	logic [crr_pkg::CMP_W-1:0]     need;
	logic [crr_pkg::CMP_W-1:0]     svb_full;
	logic [crr_pkg::CNT_W-1:0]     left_nx;
	logic                          pres;
	logic                          out_free;

	logic                          ld_req;
	logic                          ld_s1;
	logic                          ld_out;
	logic                          adv;
	crr_pkg::res_t                 res_d;

	logic                          ram_wr_en;
	logic [crr_pkg::ROW_W-1:0]     ram_wr_addr;
	logic [crr_pkg::ROW_BITS-1:0]  ram_wr_data;
	logic                          ram_rd_en;
	logic [crr_pkg::ROW_BITS-1:0]  ram_rd_data;

	// Present bitmap, one row of blocks per word
	crr_ram #(
		.WIDTH (crr_pkg::ROW_BITS),
		.DEPTH (crr_pkg::ROWS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (cur_blk[crr_pkg::MAP_W-1:crr_pkg::ROW_SEL_W]),
		.rd_data (ram_rd_data)
	);

	// Chunk geometry at the cursor
	assign cur_blk = cur_q >> crr_pkg::BOFF_W;
	assign room    = crr_pkg::LEN_W'(crr_pkg::BLOCK_BYTES)
		- crr_pkg::LEN_W'(cur_q[crr_pkg::BOFF_W-1:0]);
	assign len_c   = (crr_pkg::CNT_W'(room) > left_q) ? crr_pkg::LEN_W'(left_q) : room;

	// Original-source window: writes seed from the block start
	assign pos      = func_q ? (cur_blk << crr_pkg::BOFF_W) : cur_q;
	assign pos_cmp  = crr_pkg::CMP_W'(pos);
	assign size_cmp = crr_pkg::CMP_W'(cfg.orig_size);

	// Decide-stage values
	assign pres     = ram_rd_data[map_idx_s1[crr_pkg::ROW_SEL_W-1:0]];
	assign need     = func_q ? crr_pkg::CMP_W'(crr_pkg::BLOCK_BYTES) : crr_pkg::CMP_W'(len_s1);
	assign svb_full = (avail_s1 < need) ? avail_s1 : need;
	assign left_nx  = left_q - crr_pkg::CNT_W'(len_s1);
	assign out_free = !out_valid_q || m_tready;

	assign ram_wr_addr = (state_q == crr_pkg::BK_CLEAR) ? clr_q :
		map_idx_s1[crr_pkg::MAP_W-1:crr_pkg::ROW_SEL_W];
	assign ram_wr_data = (state_q == crr_pkg::BK_CLEAR) ? '0 :
		(ram_rd_data | (crr_pkg::ROW_BITS'(1) << map_idx_s1[crr_pkg::ROW_SEL_W-1:0]));

	// Sequencer: next state and controls
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ld_req    = 1'b0;
		ld_s1     = 1'b0;
		ld_out    = 1'b0;
		adv       = 1'b0;
		ram_wr_en = 1'b0;
		ram_rd_en = 1'b0;

		res_d.blk    = blkn_s1;
		res_d.boff   = crr_pkg::BOFFO_W'(boff_s1);
		res_d.chunk  = crr_pkg::CHUNK_W'(len_s1);
		res_d.act    = crr_pkg::ACT_NONE;
		res_d.svb    = '0;
		res_d.status = crr_pkg::STAT_OK;
		res_d.last   = left_nx == '0;

		unique case (state_q)
			crr_pkg::BK_CLEAR: begin
				ram_wr_en = 1'b1;
				if (clr_q == crr_pkg::ROW_W'(crr_pkg::ROWS - 1)) begin
					state_d = crr_pkg::BK_IDLE;
				end
			end
			crr_pkg::BK_IDLE: begin
				if (!empty) begin
					if (head.special) begin
						// Single result for an empty or refused request
						res_d.blk    = crr_pkg::BLKN_W'(head.off >> crr_pkg::BOFF_W);
						res_d.boff   = crr_pkg::BOFFO_W'(head.off[crr_pkg::BOFF_W-1:0]);
						res_d.chunk  = '0;
						res_d.status = head.status;
						res_d.last   = 1'b1;
						if (out_free) begin
							ld_out = 1'b1;
							pop    = 1'b1;
						end
					end else begin
						pop     = 1'b1;
						ld_req  = 1'b1;
						state_d = crr_pkg::BK_ISSUE;
					end
				end
			end
			crr_pkg::BK_ISSUE: begin
				ld_s1   = 1'b1;
				state_d = crr_pkg::BK_DECIDE;
			end
			crr_pkg::BK_DECIDE: begin
				ram_rd_en = 1'b0;
				if (!func_q) begin
					if (pres && cfg.ov_present) begin
						res_d.act = crr_pkg::ACT_OV_READ;
					end else begin
						res_d.act = crr_pkg::ACT_ORIG_READ;
						res_d.svb = crr_pkg::SVB_W'(svb_full);
					end
				end else if (len_s1 == crr_pkg::LEN_W'(crr_pkg::BLOCK_BYTES)) begin
					res_d.act = crr_pkg::ACT_FULL_WRITE;
				end else if (pres) begin
					res_d.act = crr_pkg::ACT_SEED_OV;
				end else begin
					res_d.act = crr_pkg::ACT_SEED_ORIG;
					res_d.svb = crr_pkg::SVB_W'(svb_full);
				end
				if (out_free) begin
					ld_out    = 1'b1;
					adv       = 1'b1;
					ram_wr_en = func_q;
					state_d   = (left_nx == '0) ? crr_pkg::BK_IDLE : crr_pkg::BK_ISSUE;
				end
			end
			default: state_d = crr_pkg::BK_IDLE;
		endcase

		// Bitmap row for the chunk is read on the way into the decide step
		if (state_q == crr_pkg::BK_ISSUE) begin
			ram_rd_en = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crr_pkg::BK_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			left_q      <= '0;
			func_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == crr_pkg::BK_CLEAR) begin
				clr_q <= clr_q + crr_pkg::ROW_W'(1);
			end
			if (ld_req) begin
				cur_q  <= crr_pkg::CUR_W'(head.off);
				left_q <= head.cnt;
				func_q <= head.func;
			end else if (adv) begin
				cur_q  <= cur_q + crr_pkg::CUR_W'(len_s1);
				left_q <= left_nx;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Chunk stage and result register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			map_idx_s1 <= crr_pkg::MAP_W'(cur_blk);
			blkn_s1    <= crr_pkg::BLKN_W'(cur_blk);
			boff_s1    <= cur_q[crr_pkg::BOFF_W-1:0];
			len_s1     <= len_c;
			avail_s1   <= (cfg.has_orig && (pos_cmp < size_cmp)) ? (size_cmp - pos_cmp) : '0;
		end
		if (ld_out) begin
			out_q <= res_d;
		end
	end

	assign clr_done = state_q != crr_pkg::BK_CLEAR;
	assign m_valid  = out_valid_q;
	assign res      = out_q;

endmodule
